// ===== hdl/cmbs_pkg.sv =====
// Package with the shared types, constants and helpers of the chat markup block splitter.
`timescale 1ns / 1ps
`default_nettype none
package cmbs_pkg;

  // Marker characters.
  localparam logic [7:0] CH_TICK      = 8'h60;
  localparam logic [7:0] CH_DASH      = 8'h2D;
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_LBRACKET  = 8'h5B;
  localparam logic [7:0] CH_RBRACKET  = 8'h5D;
  localparam logic [7:0] CH_NEWLINE   = 8'h0A;

  // UTF-8 lead byte masks and patterns.
  localparam logic [7:0] UTF8_MASK1 = 8'h80;
  localparam logic [7:0] UTF8_MASK2 = 8'hE0;
  localparam logic [7:0] UTF8_LEAD2 = 8'hC0;
  localparam logic [7:0] UTF8_MASK3 = 8'hF0;
  localparam logic [7:0] UTF8_LEAD3 = 8'hE0;
  localparam logic [7:0] UTF8_MASK4 = 8'hF8;
  localparam logic [7:0] UTF8_LEAD4 = 8'hF0;

  localparam logic [15:0] LINES_MAX = 16'hFFFF;

  typedef enum logic [1:0] {
    MODE_TEXT = 2'd0,
    MODE_LANG = 2'd1,
    MODE_BODY = 2'd2,
    MODE_MATH = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    RES_CONTENT = 2'd0,
    RES_CLOSED  = 2'd1,
    RES_MSG_END = 2'd2
  } res_type_t;

  typedef enum logic [2:0] {
    ROLE_TEXT = 3'd0,
    ROLE_LANG = 3'd1,
    ROLE_BODY = 3'd2,
    ROLE_MATH = 3'd3,
    ROLE_SEP  = 3'd4
  } role_t;

  // One result as it waits in the output queue.
  typedef struct packed {
    res_type_t   rtype;
    role_t       role;
    logic [7:0]  value;
    logic [15:0] lines;
    logic        last;
  } res_t;

  // Parser state apart from the newline tally.
  typedef struct packed {
    logic [2:0][7:0] win;
    logic [1:0]      fill;
    mode_t           mode;
    logic            text_open;
    logic [1:0]      utf8_rem;
    logic            after_nl;
  } pstate_t;

  // Number of continuation bytes that follow a byte; malformed leads count as single bytes.
  function automatic logic [1:0] utf8_follow(input logic [7:0] c);
    logic [1:0] r;
    r = 2'd0;
    if ((c & UTF8_MASK1) == 8'h00) r = 2'd0;
    else if ((c & UTF8_MASK2) == UTF8_LEAD2) r = 2'd1;
    else if ((c & UTF8_MASK3) == UTF8_LEAD3) r = 2'd2;
    else if ((c & UTF8_MASK4) == UTF8_LEAD4) r = 2'd3;
    return r;
  endfunction

  // Builds a result with the given fields and the final flag clear.
  function automatic res_t mk_res(input res_type_t t, input role_t r, input logic [7:0] v,
                                  input logic [15:0] n);
    res_t x;
    x.rtype = t;
    x.role  = r;
    x.value = v;
    x.lines = n;
    x.last  = 1'b0;
    return x;
  endfunction

endpackage
`default_nettype wire

// ===== hdl/cmbs_in_if.sv =====
// Input channel carrying message bytes with the end-of-message flag.
`timescale 1ns / 1ps
`default_nettype none
interface cmbs_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_message;

  modport source (output valid, output in_byte, output end_of_message, input ready);
  modport sink (input valid, input in_byte, input end_of_message, output ready);
endinterface
`default_nettype wire

// ===== hdl/cmbs_out_if.sv =====
// Output channel carrying tagged content bytes and block events.
`timescale 1ns / 1ps
`default_nettype none
interface cmbs_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  result_type;
  logic [2:0]  block_role;
  logic [7:0]  content_value;
  logic [15:0] code_line_count;
  logic        run_final;

  modport source (output valid, output result_type, output block_role, output content_value,
                  output code_line_count, output run_final, input ready);
  modport sink (input valid, input result_type, input block_role, input content_value,
                input code_line_count, input run_final, output ready);
endinterface
`default_nettype wire

// ===== hdl/chat_markup_block_splitter.sv =====
// Top level of the chat markup block splitter: parser step logic and result queue.
`timescale 1ns / 1ps
`default_nettype none
// The splitter takes one message byte per transaction and cuts the message into text, fenced
// code (language tag, then body), display math and separator blocks. Decisions look three
// bytes ahead, so the content result of a byte appears once two further bytes have arrived
// or when end_of_message flushes the window. Each accepted byte is handled in the cycle it is
// taken and yields at most two results, written into a four-entry result queue that drains
// one result per cycle while the reader is ready; outside a message-end flush the block
// takes a byte in every cycle while the queue holds two results or fewer, so with a steady
// reader and at most one result per byte it runs at one byte per cycle. After a byte
// flagged end_of_message it takes no byte during the parse decisions on the bytes still in
// the window (at most three, fewer when a marker takes several bytes at once) and the closing
// step, each gated by queue room; it emits the pending block close and the message end.
module chat_markup_block_splitter #(
  parameter int LINE_COUNT_BITS = 16
) (
  input  wire            clk,
  input  wire            rst,
  cmbs_in_if.sink        msg,
  cmbs_out_if.source     res
);

  localparam int LB = LINE_COUNT_BITS;

  // Parser state.
  cmbs_pkg::pstate_t st, st_next;
  logic [LB-1:0]     tally, tally_next;
  logic              flushing, flushing_next;

  // Result queue.
  cmbs_pkg::res_t    qmem [4];
  logic [1:0]        wr_ptr, rd_ptr;
  logic [2:0]        count;

  // Step logic signals.
  cmbs_pkg::pstate_t cur, dec;
  logic [LB-1:0]     dec_tally;
  cmbs_pkg::res_t    slot [2];
  logic [1:0]        n_res;
  logic [1:0]        k;
  logic              room, msg_fire, pop, do_decide, do_close, fence;
  logic              do_body;
  cmbs_pkg::role_t   body_role;
  logic [7:0]        b0, b1, b2;

  // Line count of a closed code block: newlines plus one, saturating.
  function automatic logic [15:0] code_lines(input logic [LB-1:0] t);
    logic [LB:0] n;
    n = (&t) ? {1'b0, t} : {1'b0, t} + (LB+1)'(1);
    if (33'(n) > 33'(cmbs_pkg::LINES_MAX)) return cmbs_pkg::LINES_MAX;
    return 16'(n);
  endfunction

  assign room     = (count <= 3'd2);
  assign msg.ready = !flushing && room;
  assign msg_fire = msg.valid && msg.ready;
  assign pop      = res.valid && res.ready;

  // Window after the incoming byte, and which kind of step runs this cycle.
  always_comb begin
    cur = st;
    if (msg_fire) begin
      cur.win[st.fill] = msg.in_byte;
      cur.fill = st.fill + 2'd1;
    end
    do_decide = msg_fire ? (!msg.end_of_message && cur.fill == 2'd3)
                         : (flushing && room && st.fill != 2'd0);
    do_close  = flushing && room && st.fill == 2'd0;
  end

  // One parse decision on the head of the window, or the closing step at message end.
  always_comb begin
    dec       = cur;
    dec_tally = tally;
    k         = 2'd0;
    n_res     = 2'd0;
    do_body   = 1'b0;
    body_role = cmbs_pkg::ROLE_TEXT;
    slot[0]   = '0;
    slot[1]   = '0;
    b0        = cur.win[0];
    b1        = cur.win[1];
    b2        = cur.win[2];
    fence     = cur.fill == 2'd3 && b0 == cmbs_pkg::CH_TICK && b1 == cmbs_pkg::CH_TICK &&
                b2 == cmbs_pkg::CH_TICK;

    if (do_decide) begin
      unique case (cur.mode)
        cmbs_pkg::MODE_TEXT: begin
          priority if (cur.utf8_rem != 2'd0) begin
            dec.text_open = 1'b1;
            do_body = 1'b1;
          end else if (fence) begin
            if (cur.text_open) begin
              slot[n_res[0]] = cmbs_pkg::mk_res(cmbs_pkg::RES_CLOSED, cmbs_pkg::ROLE_TEXT,
                                                8'h00, 16'h0000);
              n_res = n_res + 2'd1;
            end
            dec.text_open = 1'b0;
            dec.mode = cmbs_pkg::MODE_LANG;
            k = 2'd3;
          end else if (cur.fill >= 2'd2 && b0 == cmbs_pkg::CH_BACKSLASH &&
                       b1 == cmbs_pkg::CH_LBRACKET) begin
            if (cur.text_open) begin
              slot[n_res[0]] = cmbs_pkg::mk_res(cmbs_pkg::RES_CLOSED, cmbs_pkg::ROLE_TEXT,
                                                8'h00, 16'h0000);
              n_res = n_res + 2'd1;
            end
            dec.text_open = 1'b0;
            dec.mode = cmbs_pkg::MODE_MATH;
            k = 2'd2;
          end else if (cur.after_nl && cur.fill == 2'd3 && b0 == cmbs_pkg::CH_DASH &&
                       b1 == cmbs_pkg::CH_DASH && b2 == cmbs_pkg::CH_DASH) begin
            if (cur.text_open) begin
              slot[n_res[0]] = cmbs_pkg::mk_res(cmbs_pkg::RES_CLOSED, cmbs_pkg::ROLE_TEXT,
                                                8'h00, 16'h0000);
              n_res = n_res + 2'd1;
            end
            dec.text_open = 1'b0;
            slot[n_res[0]] = cmbs_pkg::mk_res(cmbs_pkg::RES_CLOSED, cmbs_pkg::ROLE_SEP,
                                              8'h00, 16'h0000);
            n_res = n_res + 2'd1;
            k = 2'd3;
          end else begin
            dec.text_open = 1'b1;
            do_body = 1'b1;
          end
        end
        cmbs_pkg::MODE_LANG: begin
          if (b0 == cmbs_pkg::CH_NEWLINE) begin
            dec.mode     = cmbs_pkg::MODE_BODY;
            dec_tally    = '0;
            dec.utf8_rem = 2'd0;
          end else begin
            slot[0] = cmbs_pkg::mk_res(cmbs_pkg::RES_CONTENT, cmbs_pkg::ROLE_LANG, b0, 16'h0000);
            n_res = 2'd1;
          end
          k = 2'd1;
        end
        cmbs_pkg::MODE_BODY: begin
          if (cur.utf8_rem == 2'd0 && fence) begin
            slot[0] = cmbs_pkg::mk_res(cmbs_pkg::RES_CLOSED, cmbs_pkg::ROLE_BODY, 8'h00,
                                       code_lines(tally));
            n_res = 2'd1;
            dec_tally    = '0;
            dec.utf8_rem = 2'd0;
            dec.mode     = cmbs_pkg::MODE_TEXT;
            k = 2'd3;
          end else begin
            do_body = 1'b1;
            body_role = cmbs_pkg::ROLE_BODY;
          end
        end
        cmbs_pkg::MODE_MATH: begin
          if (cur.utf8_rem == 2'd0 && cur.fill >= 2'd2 && b0 == cmbs_pkg::CH_BACKSLASH &&
              b1 == cmbs_pkg::CH_RBRACKET) begin
            slot[0] = cmbs_pkg::mk_res(cmbs_pkg::RES_CLOSED, cmbs_pkg::ROLE_MATH, 8'h00,
                                       16'h0000);
            n_res = 2'd1;
            dec.mode = cmbs_pkg::MODE_TEXT;
            k = 2'd2;
          end else begin
            do_body = 1'b1;
            body_role = cmbs_pkg::ROLE_MATH;
          end
        end
        default: ;
      endcase

      // A content byte of text, body or math, with UTF-8 tracking.
      if (do_body) begin
        slot[0] = cmbs_pkg::mk_res(cmbs_pkg::RES_CONTENT, body_role, b0, 16'h0000);
        n_res = 2'd1;
        if (body_role == cmbs_pkg::ROLE_BODY && b0 == cmbs_pkg::CH_NEWLINE && !(&tally))
          dec_tally = tally + LB'(1);
        if (cur.utf8_rem != 2'd0) dec.utf8_rem = cur.utf8_rem - 2'd1;
        else dec.utf8_rem = cmbs_pkg::utf8_follow(b0);
        k = 2'd1;
      end

      // Drop the consumed bytes from the head of the window.
      if (k > cur.fill) k = cur.fill;
      unique case (k)
        2'd1: begin
          dec.after_nl = (cur.win[0] == cmbs_pkg::CH_NEWLINE);
          dec.win[0] = cur.win[1];
          dec.win[1] = cur.win[2];
        end
        2'd2: begin
          dec.after_nl = (cur.win[1] == cmbs_pkg::CH_NEWLINE);
          dec.win[0] = cur.win[2];
        end
        2'd3: dec.after_nl = (cur.win[2] == cmbs_pkg::CH_NEWLINE);
        default: ;
      endcase
      dec.fill = cur.fill - k;
    end else if (do_close) begin
      // Close whatever block is still open, then report message end.
      unique case (cur.mode)
        cmbs_pkg::MODE_LANG: begin
          slot[0] = cmbs_pkg::mk_res(cmbs_pkg::RES_CLOSED, cmbs_pkg::ROLE_BODY, 8'h00, 16'h0001);
          n_res = 2'd1;
        end
        cmbs_pkg::MODE_BODY: begin
          slot[0] = cmbs_pkg::mk_res(cmbs_pkg::RES_CLOSED, cmbs_pkg::ROLE_BODY, 8'h00,
                                     code_lines(tally));
          n_res = 2'd1;
        end
        cmbs_pkg::MODE_MATH: begin
          slot[0] = cmbs_pkg::mk_res(cmbs_pkg::RES_CLOSED, cmbs_pkg::ROLE_MATH, 8'h00, 16'h0000);
          n_res = 2'd1;
        end
        cmbs_pkg::MODE_TEXT: begin
          if (cur.text_open) begin
            slot[0] = cmbs_pkg::mk_res(cmbs_pkg::RES_CLOSED, cmbs_pkg::ROLE_TEXT, 8'h00,
                                       16'h0000);
            n_res = 2'd1;
          end
        end
        default: ;
      endcase
      slot[n_res[0]] = cmbs_pkg::mk_res(cmbs_pkg::RES_MSG_END, cmbs_pkg::ROLE_TEXT, 8'h00,
                                        16'h0000);
      n_res = n_res + 2'd1;
    end

    // Flag the last result caused by an input byte.
    if (n_res != 2'd0 && (msg_fire || do_close)) slot[n_res[0] ^ 1'b1].last = 1'b1;
  end

  // Next parser state.
  always_comb begin
    st_next       = dec;
    tally_next    = dec_tally;
    flushing_next = flushing || (msg_fire && msg.end_of_message);
    if (do_close) begin
      st_next          = '0;
      st_next.mode     = cmbs_pkg::MODE_TEXT;
      st_next.after_nl = 1'b1;
      tally_next       = '0;
      flushing_next    = 1'b0;
    end
  end

  // Parser state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      st       <= '{win: '0, fill: 2'd0, mode: cmbs_pkg::MODE_TEXT, text_open: 1'b0,
                    utf8_rem: 2'd0, after_nl: 1'b1};
      tally    <= '0;
      flushing <= 1'b0;
    end else begin
      st       <= st_next;
      tally    <= tally_next;
      flushing <= flushing_next;
    end
  end

  // Result queue pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 2'd0;
      rd_ptr <= 2'd0;
      count  <= 3'd0;
    end else begin
      wr_ptr <= wr_ptr + n_res;
      if (pop) rd_ptr <= rd_ptr + 2'd1;
      count <= count + {1'b0, n_res} - {2'b00, pop};
    end
  end

  // Result queue storage.
  always_ff @(posedge clk) begin
    if (n_res != 2'd0) qmem[wr_ptr] <= slot[0];
    if (n_res == 2'd2) qmem[wr_ptr + 2'd1] <= slot[1];
  end

  // Head of the queue drives the output channel.
  assign res.valid           = (count != 3'd0);
  assign res.result_type     = qmem[rd_ptr].rtype;
  assign res.block_role      = qmem[rd_ptr].role;
  assign res.content_value   = qmem[rd_ptr].value;
  assign res.code_line_count = qmem[rd_ptr].lines;
  assign res.run_final       = qmem[rd_ptr].last;

endmodule
`default_nettype wire

// ===== test/testbench.sv =====
// Self-checking testbench of the chat markup block splitter with a byte-level parser predictor.
`timescale 1ns / 1ps
module testbench;

  localparam int CLK_PERIOD      = 10;
  localparam int RESET_CYCLES    = 9;
  localparam int LINE_COUNT_BITS = 16;
  localparam int MAX_RESULTS     = 8;
  localparam int RX_HOLD_CYCLES  = 200;
  localparam int PHASE_BYTES     = 65;
  localparam int SHORT_PHASE     = 40;
  localparam int CYCLE_LIMIT     = 50000;
  localparam int DRAIN_CYCLES    = 16;
  localparam longint unsigned LINE_LIMIT = (64'd1 << LINE_COUNT_BITS) - 64'd1;

  // One message byte waiting to be offered.
  typedef struct {
    logic [7:0] data;
    logic       last;
  } msg_byte_t;

  // One result the splitter should produce.
  typedef struct {
    cmbs_pkg::res_type_t kind;
    cmbs_pkg::role_t     role;
    logic [7:0]          value;
    logic [15:0]         lines;
    logic                last;
  } block_event_t;

  logic clk = 1'b0;
  logic rst;

  cmbs_in_if  in_ch ();
  cmbs_out_if out_ch ();

  chat_markup_block_splitter #(
    .LINE_COUNT_BITS(LINE_COUNT_BITS)
  ) uut (
    .clk(clk),
    .rst(rst),
    .msg(in_ch),
    .res(out_ch)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  msg_byte_t    pending_bytes[$];
  logic [7:0]   msg_buf[$];
  block_event_t step_events[$];
  block_event_t expected_events[$];
  int           send_idle_pct;
  int           recv_idle_pct;
  logic         rx_hold = 1'b0;
  int           errors = 0;
  int           bytes_queued = 0;
  int           cycle_count;

  // Predicted parser state.
  logic [7:0]      sp_win[3];
  int              sp_fill;
  cmbs_pkg::mode_t sp_mode;
  logic            sp_text_open;
  logic [1:0]      sp_utf8_left;
  logic            sp_after_nl;
  longint unsigned sp_nl_tally;

  function automatic void splitter_reset();
    for (int i = 0; i < 3; i++) sp_win[i] = 8'h00;
    sp_fill      = 0;
    sp_mode      = cmbs_pkg::MODE_TEXT;
    sp_text_open = 1'b0;
    sp_utf8_left = 2'd0;
    sp_after_nl  = 1'b1;
    sp_nl_tally  = 0;
  endfunction

  // Continuation bytes owed after a byte; a malformed lead stands alone.
  function automatic logic [1:0] utf8_tail_count(logic [7:0] c);
    if ((c & cmbs_pkg::UTF8_MASK1) == 8'h00) return 2'd0;
    if ((c & cmbs_pkg::UTF8_MASK2) == cmbs_pkg::UTF8_LEAD2) return 2'd1;
    if ((c & cmbs_pkg::UTF8_MASK3) == cmbs_pkg::UTF8_LEAD3) return 2'd2;
    if ((c & cmbs_pkg::UTF8_MASK4) == cmbs_pkg::UTF8_LEAD4) return 2'd3;
    return 2'd0;
  endfunction

  function automatic void add_event(cmbs_pkg::res_type_t k, cmbs_pkg::role_t r,
                                    logic [7:0] v, logic [15:0] n);
    block_event_t e;
    if (step_events.size() >= MAX_RESULTS) return;
    e.kind  = k;
    e.role  = r;
    e.value = v;
    e.lines = n;
    e.last  = 1'b0;
    step_events.insert(step_events.size(), e);
  endfunction

  function automatic void drop_window(int k);
    int n;
    n = (k > sp_fill) ? sp_fill : k;
    if (n == 0) return;
    sp_after_nl = (sp_win[n - 1] == cmbs_pkg::CH_NEWLINE);
    for (int i = 0; i + n < 3; i++) sp_win[i] = sp_win[i + n];
    sp_fill -= n;
  endfunction

  function automatic bit fence_ahead(int avail);
    return avail >= 3 && sp_win[0] == cmbs_pkg::CH_TICK && sp_win[1] == cmbs_pkg::CH_TICK &&
           sp_win[2] == cmbs_pkg::CH_TICK;
  endfunction

  function automatic void close_text_block();
    if (sp_text_open) begin
      add_event(cmbs_pkg::RES_CLOSED, cmbs_pkg::ROLE_TEXT, 8'h00, 16'd0);
      sp_text_open = 1'b0;
    end
  endfunction

  function automatic void close_code_block();
    longint unsigned n;
    n = sp_nl_tally + 1;
    if (n > LINE_LIMIT) n = LINE_LIMIT;
    if (n > 64'hFFFF) n = 64'hFFFF;
    add_event(cmbs_pkg::RES_CLOSED, cmbs_pkg::ROLE_BODY, 8'h00, n[15:0]);
    sp_nl_tally  = 0;
    sp_utf8_left = 2'd0;
    sp_mode      = cmbs_pkg::MODE_TEXT;
  endfunction

  // Emits one content byte and tracks UTF-8 continuation and body newlines.
  function automatic void take_content(cmbs_pkg::role_t r, logic [7:0] b);
    add_event(cmbs_pkg::RES_CONTENT, r, b, 16'd0);
    if (r == cmbs_pkg::ROLE_BODY && b == cmbs_pkg::CH_NEWLINE && sp_nl_tally < LINE_LIMIT)
      sp_nl_tally++;
    if (sp_utf8_left != 2'd0) sp_utf8_left = sp_utf8_left - 2'd1;
    else sp_utf8_left = utf8_tail_count(b);
    drop_window(1);
  endfunction

  // Decides what the byte at the head of the window is.
  function automatic void parse_head(int avail);
    logic [7:0] b;
    b = sp_win[0];
    case (sp_mode)
      cmbs_pkg::MODE_TEXT: begin
        if (sp_utf8_left != 2'd0) begin
          sp_text_open = 1'b1;
          take_content(cmbs_pkg::ROLE_TEXT, b);
        end else if (fence_ahead(avail)) begin
          close_text_block();
          sp_mode = cmbs_pkg::MODE_LANG;
          drop_window(3);
        end else if (avail >= 2 && b == cmbs_pkg::CH_BACKSLASH &&
                     sp_win[1] == cmbs_pkg::CH_LBRACKET) begin
          close_text_block();
          sp_mode = cmbs_pkg::MODE_MATH;
          drop_window(2);
        end else if (sp_after_nl && avail >= 3 && b == cmbs_pkg::CH_DASH &&
                     sp_win[1] == cmbs_pkg::CH_DASH && sp_win[2] == cmbs_pkg::CH_DASH) begin
          close_text_block();
          add_event(cmbs_pkg::RES_CLOSED, cmbs_pkg::ROLE_SEP, 8'h00, 16'd0);
          drop_window(3);
        end else begin
          sp_text_open = 1'b1;
          take_content(cmbs_pkg::ROLE_TEXT, b);
        end
      end
      cmbs_pkg::MODE_LANG: begin
        if (b == cmbs_pkg::CH_NEWLINE) begin
          sp_mode      = cmbs_pkg::MODE_BODY;
          sp_nl_tally  = 0;
          sp_utf8_left = 2'd0;
        end else begin
          add_event(cmbs_pkg::RES_CONTENT, cmbs_pkg::ROLE_LANG, b, 16'd0);
        end
        drop_window(1);
      end
      cmbs_pkg::MODE_BODY: begin
        if (sp_utf8_left == 2'd0 && fence_ahead(avail)) begin
          close_code_block();
          drop_window(3);
        end else begin
          take_content(cmbs_pkg::ROLE_BODY, b);
        end
      end
      default: begin
        if (sp_utf8_left == 2'd0 && avail >= 2 && b == cmbs_pkg::CH_BACKSLASH &&
            sp_win[1] == cmbs_pkg::CH_RBRACKET) begin
          add_event(cmbs_pkg::RES_CLOSED, cmbs_pkg::ROLE_MATH, 8'h00, 16'd0);
          sp_mode = cmbs_pkg::MODE_TEXT;
          drop_window(2);
        end else begin
          take_content(cmbs_pkg::ROLE_MATH, b);
        end
      end
    endcase
  endfunction

  // Works out the results caused by one accepted byte and queues them.
  function automatic void predict_byte(logic [7:0] b, logic eom);
    block_event_t e;
    step_events.delete();
    if (sp_fill < 3) begin
      sp_win[sp_fill] = b;
      sp_fill++;
    end
    if (!eom) begin
      if (sp_fill == 3) parse_head(3);
    end else begin
      while (sp_fill > 0) parse_head(sp_fill);
      if (sp_mode == cmbs_pkg::MODE_LANG) begin
        sp_nl_tally = 0;
        close_code_block();
      end else if (sp_mode == cmbs_pkg::MODE_BODY) begin
        close_code_block();
      end else if (sp_mode == cmbs_pkg::MODE_MATH) begin
        add_event(cmbs_pkg::RES_CLOSED, cmbs_pkg::ROLE_MATH, 8'h00, 16'd0);
      end else begin
        close_text_block();
      end
      add_event(cmbs_pkg::RES_MSG_END, cmbs_pkg::ROLE_TEXT, 8'h00, 16'd0);
      splitter_reset();
    end
    foreach (step_events[i]) begin
      e = step_events[i];
      e.last = (i == step_events.size() - 1);
      expected_events.insert(expected_events.size(), e);
    end
  endfunction

  function automatic void check_field(string name, int unsigned exp_v, int unsigned act_v);
    if (exp_v != act_v) begin
      $error("%s mismatch: expected %0d, actual %0d", name, exp_v, act_v);
      errors++;
    end
  endfunction

  // Driver: offers the next pending byte whenever the current transaction is done.
  always @(posedge clk) begin : driver
    msg_byte_t it;
    if (rst) begin
      in_ch.valid          <= 1'b0;
      in_ch.in_byte        <= 8'h00;
      in_ch.end_of_message <= 1'b0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (pending_bytes.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        it = pending_bytes.pop_front();
        in_ch.valid          <= 1'b1;
        in_ch.in_byte        <= it.data;
        in_ch.end_of_message <= it.last;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Receiver readiness with random idling and the long hold-off.
  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= !rx_hold && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Monitor: predicts on every input transaction and checks every output transaction.
  always @(posedge clk) begin : monitor
    block_event_t e;
    if (!rst) begin
      if (in_ch.valid && in_ch.ready) predict_byte(in_ch.in_byte, in_ch.end_of_message);
      if (out_ch.valid && out_ch.ready) begin
        if (expected_events.size() == 0) begin
          $error("result with nothing expected: type %0d role %0d value %0d",
                 out_ch.result_type, out_ch.block_role, out_ch.content_value);
          errors++;
        end else begin
          e = expected_events.pop_front();
          check_field("result_type", e.kind, out_ch.result_type);
          check_field("block_role", e.role, out_ch.block_role);
          check_field("content_value", e.value, out_ch.content_value);
          check_field("code_line_count", e.lines, out_ch.code_line_count);
          check_field("run_final", e.last, out_ch.run_final);
        end
      end
    end
  end

  // Message building helpers.
  task automatic put(logic [7:0] b);
    msg_buf.insert(msg_buf.size(), b);
  endtask

  task automatic put_text(string s);
    for (int i = 0; i < s.len(); i++) put(s[i]);
  endtask

  task automatic put_fence();
    repeat (3) put(cmbs_pkg::CH_TICK);
  endtask

  // Moves the built message into the pending queue, flagging its final byte.
  task automatic end_message();
    msg_byte_t it;
    if (msg_buf.size() == 0) put(8'($urandom_range(255)));
    foreach (msg_buf[i]) begin
      it.data = msg_buf[i];
      it.last = (i == msg_buf.size() - 1);
      pending_bytes.insert(pending_bytes.size(), it);
    end
    bytes_queued += msg_buf.size();
    msg_buf.delete();
  endtask

  // A UTF-8 lead with its continuation bytes, now and then hiding a marker character.
  task automatic put_utf8();
    int k;
    k = $urandom_range(3, 1);
    case (k)
      1: put(8'hC0 | 8'($urandom_range(31)));
      2: put(8'hE0 | 8'($urandom_range(15)));
      default: put(8'hF0 | 8'($urandom_range(7)));
    endcase
    repeat (k) begin
      case ($urandom_range(5))
        0: put(cmbs_pkg::CH_TICK);
        1: put(cmbs_pkg::CH_NEWLINE);
        2: put(cmbs_pkg::CH_BACKSLASH);
        3: put(cmbs_pkg::CH_RBRACKET);
        default: put(8'h80 | 8'($urandom_range(63)));
      endcase
    end
  endtask

  task automatic put_random_text(int n);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(9))
        0: put(cmbs_pkg::CH_NEWLINE);
        1: put_utf8();
        2: put(8'($urandom_range(255)));
        default: put(8'($urandom_range(8'h7E, 8'h20)));
      endcase
    end
  endtask

  task automatic put_noise(int n);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(7))
        0: put(cmbs_pkg::CH_TICK);
        1: put(cmbs_pkg::CH_DASH);
        2: put(cmbs_pkg::CH_BACKSLASH);
        3: put(cmbs_pkg::CH_LBRACKET);
        4: put(cmbs_pkg::CH_RBRACKET);
        5: put(cmbs_pkg::CH_NEWLINE);
        6: put(8'hC0 | 8'($urandom_range(63)));
        default: put(8'($urandom_range(255)));
      endcase
    end
  endtask

  task automatic put_code_block();
    put_fence();
    repeat ($urandom_range(4)) begin
      if ($urandom_range(5) == 0) put(8'($urandom_range(255)));
      else put(8'($urandom_range(8'h7A, 8'h61)));
    end
    if ($urandom_range(9) != 0) begin
      put(cmbs_pkg::CH_NEWLINE);
      repeat ($urandom_range(3)) begin
        put_random_text($urandom_range(5));
        if ($urandom_range(5) == 0) begin
          put(cmbs_pkg::CH_TICK);
          put(cmbs_pkg::CH_TICK);
        end
        put(cmbs_pkg::CH_NEWLINE);
      end
      if ($urandom_range(9) != 0) put_fence();
    end
  endtask

  task automatic put_math_block();
    put_text("\\[");
    put_random_text($urandom_range(5));
    if ($urandom_range(9) != 0) put_text("\\]");
  endtask

  // Mostly well-formed messages built from blocks, the rest marker-heavy noise.
  task automatic random_message();
    if ($urandom_range(4) == 0) begin
      put_noise($urandom_range(12, 1));
    end else begin
      repeat ($urandom_range(4, 1)) begin
        case ($urandom_range(4))
          0: put_random_text($urandom_range(6));
          1: put_code_block();
          2: put_math_block();
          3: put_text("\n---");
          default: put_noise($urandom_range(3, 1));
        endcase
      end
    end
    end_message();
  endtask

  task automatic random_phase(int count);
    int start_bytes;
    start_bytes = bytes_queued;
    while (bytes_queued - start_bytes < count) random_message();
  endtask

  // Waits until every byte was taken and every expected result has arrived.
  task automatic wait_drained();
    while (pending_bytes.size() != 0 || in_ch.valid) @(negedge clk);
    while (expected_events.size() != 0) @(negedge clk);
  endtask

  // Run limit.
  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("== FAIL ==");
    $finish;
  end

  initial begin : stimulus
    rst           = 1'b1;
    send_idle_pct = 30;
    recv_idle_pct = 45;
    splitter_reset();
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Separator at message start, code with a tag and an empty line, math whose
    // closing marker hides inside a UTF-8 sequence, then a malformed lead byte.
    put_text("---");
    put_fence();
    put_text("c\n\n");
    put_fence();
    put_text("\\[");
    put(8'hE2);
    put_text("\\]\\]");
    put(8'hFF);
    end_message();
    // Zero byte, then a fence cut short by the message end.
    put(8'h00);
    put(cmbs_pkg::CH_TICK);
    put(cmbs_pkg::CH_TICK);
    end_message();
    // Unclosed body whose newline rides as a UTF-8 continuation.
    put_fence();
    put(cmbs_pkg::CH_NEWLINE);
    put(8'hC2);
    put(cmbs_pkg::CH_NEWLINE);
    end_message();
    // Unclosed empty math.
    put_text("\\[");
    end_message();
    // Unclosed language tag.
    put_fence();
    put_text("x");
    end_message();
    // A fence swallowed by a four-byte lead, and a separator cut by the message end.
    put(8'hF0);
    put_fence();
    put_text("\n--");
    end_message();

    random_phase(PHASE_BYTES);
    wait_drained();

    // Second phase with the idling swapped; the drain above is the sender pause.
    send_idle_pct = 45;
    recv_idle_pct = 30;
    random_phase(PHASE_BYTES);
    wait_drained();

    // Third phase without idling; the receiver first holds off so the block backs up.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_phase(SHORT_PHASE);
    fork
      begin
        rx_hold = 1'b1;
        repeat (RX_HOLD_CYCLES) @(negedge clk);
        rx_hold = 1'b0;
      end
    join_none
    wait_drained();

    // A last stretch of back-to-back messages.
    random_phase(SHORT_PHASE);
    wait_drained();

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
